// File: src/mcrd_pkg.sv
// Package with shared types, command codes and constants of the motor CAN reply decoder.
package mcrd_pkg;

    localparam int MOTOR_SLOTS_DEF = 256;
    localparam int ROW_W = 137;

    localparam logic [10:0] RESP_BASE_RESET = 11'h240;
    localparam logic [3:0]  FULL_LENGTH     = 4'd8;

    // Reply command codes carried in data byte 0.
    localparam logic [7:0] CMD_STATUS       = 8'h9C;
    localparam logic [7:0] CMD_TORQUE       = 8'hA1;
    localparam logic [7:0] CMD_SPEED        = 8'hA2;
    localparam logic [7:0] CMD_POS_ABS      = 8'hA4;
    localparam logic [7:0] CMD_POS_INC_A6   = 8'hA6;
    localparam logic [7:0] CMD_POS_INC_A8   = 8'hA8;
    localparam logic [7:0] CMD_POS_INC_A9   = 8'hA9;
    localparam logic [7:0] CMD_MOTOR_OFF    = 8'h80;
    localparam logic [7:0] CMD_MOTOR_STOP   = 8'h81;
    localparam logic [7:0] CMD_ERROR_STATUS = 8'h9A;
    localparam logic [7:0] CMD_ANGLE        = 8'h92;
    localparam logic [7:0] CMD_ZERO_ACK     = 8'h64;

    typedef enum logic [2:0] {
        KIND_IGNORED,
        KIND_STATUS,
        KIND_ERROR,
        KIND_ANGLE,
        KIND_ZERO_ACK,
        KIND_OTHER
    } update_kind_t;

    typedef logic [10:0] base_id_t;

    typedef struct packed {
        logic        is_extended;
        logic [28:0] can_id;
        logic [3:0]  length_code;
        logic [7:0]  byte0;
        logic [7:0]  byte1;
        logic [7:0]  byte2;
        logic [7:0]  byte3;
        logic [7:0]  byte4;
        logic [7:0]  byte5;
        logic [7:0]  byte6;
        logic [7:0]  byte7;
    } frame_t;

    typedef struct packed {
        logic [2:0]         update_kind;
        logic [7:0]         motor_number;
        logic signed [7:0]  temperature;
        logic signed [15:0] current_raw;
        logic signed [15:0] velocity;
        logic [15:0]        encoder_position;
        logic [15:0]        voltage_a;
        logic [15:0]        voltage_b;
        logic signed [47:0] turn_angle;
        logic               fault;
        logic               reset_request;
    } result_t;

    // One motor's stored state, kept as a single memory row.
    typedef struct packed {
        logic [7:0]  temperature;
        logic [15:0] current_raw;
        logic [15:0] velocity;
        logic [15:0] encoder_position;
        logic [15:0] voltage_a;
        logic [15:0] voltage_b;
        logic [47:0] turn_angle;
        logic        fault;
    } row_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic finish;
    } cmd_t;

endpackage

// File: src/mcrd_chan_if.sv
// Valid/ready channel interface carrying one payload per transaction.
interface mcrd_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: src/mcrd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module mcrd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// File: src/mcrd_ctrl.sv
// Controller state machine that sequences frame capture, table lookup and result hand-off.
module mcrd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          frame_valid,
    output logic          frame_ready,
    output logic          res_valid,
    input  logic          res_ready,
    output mcrd_pkg::cmd_t cmd
);
    import mcrd_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_LOOKUP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   res_valid_reg;
    logic   res_valid_next;
    logic   res_free;

    // The result register can take a new value when empty or being emptied now.
    assign res_free = !res_valid_reg || res_ready;

    always_comb
    begin
        state_next     = state_reg;
        res_valid_next = res_valid_reg && !res_ready;
        frame_ready    = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                frame_ready = 1'b1;
                if (frame_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                if (res_free)
                begin
                    cmd.finish     = 1'b1;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

`ifndef NO_ASSERTIONS
    a_capture_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        frame_valid && frame_ready |=> state_reg == S_LOOKUP)
        else $error("accepted frame did not move to lookup");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOOKUP && res_valid_reg && !res_ready |=> state_reg == S_LOOKUP)
        else $error("lookup left while result register was full");

    a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> res_valid_reg)
        else $error("finished frame did not present a result");
`endif
endmodule

// File: src/mcrd_datapath.sv
// Datapath with base register, frame decode, state RAM with valid bits, merge and result register.
module mcrd_datapath #(
    parameter int MOTOR_SLOTS = mcrd_pkg::MOTOR_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    input  mcrd_pkg::base_id_t cfg_data,
    input  mcrd_pkg::frame_t  frame_data,
    input  mcrd_pkg::cmd_t    cmd,
    output mcrd_pkg::result_t res_data
);
    import mcrd_pkg::*;

    localparam int IDX_W = (MOTOR_SLOTS > 1) ? $clog2(MOTOR_SLOTS) : 1;

    base_id_t         base_reg;
    frame_t           frame_reg;
    logic [7:0]       motor_reg;
    logic             drop_reg;
    logic [MOTOR_SLOTS-1:0] valid_reg;
    result_t          res_reg;
    result_t          res_next;

    logic [11:0]      id_diff;
    logic [7:0]       motor_in;
    logic             drop_in;
    logic [IDX_W-1:0] idx;
    logic [ROW_W-1:0] rd_data;
    row_t             row_old;
    row_t             row_new;
    update_kind_t     kind;
    logic             full;
    logic             row_wr_en;

    // Window check: the difference must be non-negative, below 256 and below MOTOR_SLOTS.
    assign id_diff  = {1'b0, frame_data.can_id[10:0]} - {1'b0, base_reg};
    assign motor_in = id_diff[7:0];
    assign drop_in  = frame_data.is_extended || (frame_data.length_code == 4'd0) ||
                      id_diff[11] || (id_diff[10:8] != 3'd0) ||
                      (int'(motor_in) >= MOTOR_SLOTS);

    assign idx = motor_reg[IDX_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= RESP_BASE_RESET;
            valid_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                base_reg <= cfg_data;
            end
            if (row_wr_en)
            begin
                valid_reg[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            frame_reg <= frame_data;
            motor_reg <= motor_in;
            drop_reg  <= drop_in;
        end
        if (cmd.finish)
        begin
            res_reg <= res_next;
        end
    end

    mcrd_ram #(
        .WIDTH (ROW_W),
        .DEPTH (MOTOR_SLOTS)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (row_wr_en),
        .wr_addr (idx),
        .wr_data (row_new),
        .rd_en   (cmd.capture),
        .rd_addr (motor_in[IDX_W-1:0]),
        .rd_data (rd_data)
    );

    // An entry never written since reset reads as zero.
    assign row_old = valid_reg[idx] ? row_t'(rd_data) : '0;
    assign full    = (frame_reg.length_code >= FULL_LENGTH);

    always_comb
    begin
        row_new = row_old;
        kind    = KIND_OTHER;
        unique case (frame_reg.byte0) inside
            CMD_STATUS, CMD_TORQUE, CMD_SPEED, CMD_POS_ABS, CMD_POS_INC_A6,
            CMD_POS_INC_A8, CMD_POS_INC_A9, CMD_MOTOR_OFF, CMD_MOTOR_STOP:
            begin
                if (full)
                begin
                    row_new.temperature      = frame_reg.byte1;
                    row_new.current_raw      = {frame_reg.byte3, frame_reg.byte2};
                    row_new.velocity         = {frame_reg.byte5, frame_reg.byte4};
                    row_new.encoder_position = {frame_reg.byte7, frame_reg.byte6};
                    kind                     = KIND_STATUS;
                end
            end
            CMD_ERROR_STATUS:
            begin
                if (full)
                begin
                    row_new.temperature = frame_reg.byte1;
                    row_new.voltage_a   = {frame_reg.byte3, frame_reg.byte2};
                    row_new.voltage_b   = {frame_reg.byte5, frame_reg.byte4};
                    row_new.fault       = |{frame_reg.byte7, frame_reg.byte6};
                    kind                = KIND_ERROR;
                end
            end
            CMD_ANGLE:
            begin
                if (full)
                begin
                    row_new.turn_angle = {frame_reg.byte7, frame_reg.byte6, frame_reg.byte5,
                                          frame_reg.byte4, frame_reg.byte3, frame_reg.byte2};
                    kind               = KIND_ANGLE;
                end
            end
            CMD_ZERO_ACK:
            begin
                kind = KIND_ZERO_ACK;
            end
            default:
            begin
                kind = KIND_OTHER;
            end
        endcase
    end

    assign row_wr_en = cmd.finish && !drop_reg &&
                       (kind == KIND_STATUS || kind == KIND_ERROR || kind == KIND_ANGLE);

    always_comb
    begin
        res_next = '0;
        if (!drop_reg)
        begin
            res_next.update_kind      = kind;
            res_next.motor_number     = motor_reg;
            res_next.temperature      = row_new.temperature;
            res_next.current_raw      = row_new.current_raw;
            res_next.velocity         = row_new.velocity;
            res_next.encoder_position = row_new.encoder_position;
            res_next.voltage_a        = row_new.voltage_a;
            res_next.voltage_b        = row_new.voltage_b;
            res_next.turn_angle       = row_new.turn_angle;
            res_next.fault            = row_new.fault;
            res_next.reset_request    = (kind == KIND_ZERO_ACK);
        end
    end

    assign res_data = res_reg;

`ifndef NO_ASSERTIONS
    a_dropped_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish && drop_reg |=> res_reg == '0)
        else $error("dropped frame produced a nonzero result");

    a_write_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        row_wr_en |=> valid_reg[$past(idx)])
        else $error("written table row not marked valid");

    a_reset_request_kind: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> res_reg.reset_request == (res_reg.update_kind == KIND_ZERO_ACK))
        else $error("reset request does not match zero acknowledgement");
`endif
endmodule

// File: src/motor_can_response_decoder.sv
// Top level of the motor CAN reply decoder: controller, datapath and channel wiring.
//
// The block takes one received CAN frame per transaction on the frame channel
// and returns exactly one result transaction for it. Extended frames, frames of
// length zero and frames whose 11-bit identifier falls outside the 256-wide
// window starting at the configured response base (reset 0x240) come back as an
// all-zero result. Otherwise the motor number is the identifier minus the base,
// and data byte 0 selects how that motor's stored state is updated: status
// replies store temperature, current, velocity and encoder position, the error
// status reply stores temperature, both voltage words and the fault flag, the
// angle reply stores the 48-bit multi-turn angle, and the zero-set
// acknowledgement raises reset_request. Updates need a length of 8 or more; a
// shorter update frame and any other code report kind 5 and change nothing.
// The result always carries the motor's stored values after the update.
// Each frame is accepted in the idle state, which starts the read of the motor's
// state row; in the lookup state the frame is merged into the registered row and
// written back, as the single read-modify-write of the state memory per frame. The
// result register decouples the output: a new frame is accepted while a result
// still waits, and the merge cycle waits only if that result has not yet been
// taken. Per-row valid bits make the whole table read as zero right after reset,
// so no clearing pass is needed. The base register is written through the
// configuration channel, which is always ready, and must be written only while
// no frame is in flight.
module motor_can_response_decoder #(
    parameter int MOTOR_SLOTS = mcrd_pkg::MOTOR_SLOTS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    mcrd_chan_if.sink      frame,
    mcrd_chan_if.source    result,
    mcrd_chan_if.sink      cfg
);
    import mcrd_pkg::*;

    cmd_t    cmd;
    result_t res_data;

    // Configuration writes are taken in any cycle.
    assign cfg.ready = 1'b1;

    mcrd_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame.valid),
        .frame_ready (frame.ready),
        .res_valid   (result.valid),
        .res_ready   (result.ready),
        .cmd         (cmd)
    );

    mcrd_datapath #(
        .MOTOR_SLOTS (MOTOR_SLOTS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg.valid),
        .cfg_data   (cfg.payload),
        .frame_data (frame.payload),
        .cmd        (cmd),
        .res_data   (res_data)
    );

    assign result.payload = res_data;
endmodule

// File: tb/tb_motor_can_response_decoder.sv
// Self-checking testbench for the motor CAN reply decoder with a table-tracking scoreboard.
`timescale 1ns / 1ps

module tb_motor_can_response_decoder;
    import mcrd_pkg::*;

    // Tracks every motor's stored state the way the decoder should. It predicts the reply to
    // each accepted frame and checks the replies in order.
    class motor_state_board;
        base_id_t    base;
        logic [7:0]  temps    [MOTOR_SLOTS_DEF];
        logic [15:0] currents [MOTOR_SLOTS_DEF];
        logic [15:0] speeds   [MOTOR_SLOTS_DEF];
        logic [15:0] encoders [MOTOR_SLOTS_DEF];
        logic [15:0] volts_a  [MOTOR_SLOTS_DEF];
        logic [15:0] volts_b  [MOTOR_SLOTS_DEF];
        logic [47:0] angles   [MOTOR_SLOTS_DEF];
        logic        faults   [MOTOR_SLOTS_DEF];
        result_t     expected_replies [$];
        int unsigned kind_total [6];
        int unsigned failures;

        function new();
            base = RESP_BASE_RESET;
            failures = 0;
            foreach (kind_total[k])
                kind_total[k] = 0;
            foreach (temps[i])
            begin
                temps[i]    = '0;
                currents[i] = '0;
                speeds[i]   = '0;
                encoders[i] = '0;
                volts_a[i]  = '0;
                volts_b[i]  = '0;
                angles[i]   = '0;
                faults[i]   = 1'b0;
            end
        endfunction

        function void set_base(base_id_t value);
            base = value;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        // Applies one accepted frame to the tables and queues the reply it must produce.
        function void note_frame(frame_t f);
            result_t      r;
            update_kind_t kind;
            int           id;
            int           m;
            logic         full;
            logic         zero_req;
            r        = '0;
            kind     = KIND_IGNORED;
            zero_req = 1'b0;
            id       = int'(f.can_id[10:0]);
            if (!f.is_extended && f.length_code != 4'd0 && id >= int'(base)
                && id < int'(base) + MOTOR_SLOTS_DEF)
            begin
                m    = id - int'(base);
                full = (f.length_code >= FULL_LENGTH);
                kind = KIND_OTHER;
                case (f.byte0) inside
                    CMD_STATUS, CMD_TORQUE, CMD_SPEED, CMD_POS_ABS, CMD_POS_INC_A6,
                    CMD_POS_INC_A8, CMD_POS_INC_A9, CMD_MOTOR_OFF, CMD_MOTOR_STOP:
                        if (full)
                        begin
                            temps[m]    = f.byte1;
                            currents[m] = {f.byte3, f.byte2};
                            speeds[m]   = {f.byte5, f.byte4};
                            encoders[m] = {f.byte7, f.byte6};
                            kind        = KIND_STATUS;
                        end
                    CMD_ERROR_STATUS:
                        if (full)
                        begin
                            temps[m]   = f.byte1;
                            volts_a[m] = {f.byte3, f.byte2};
                            volts_b[m] = {f.byte5, f.byte4};
                            faults[m]  = ({f.byte7, f.byte6} != 16'd0);
                            kind       = KIND_ERROR;
                        end
                    CMD_ANGLE:
                        if (full)
                        begin
                            angles[m] = {f.byte7, f.byte6, f.byte5, f.byte4, f.byte3, f.byte2};
                            kind      = KIND_ANGLE;
                        end
                    CMD_ZERO_ACK:
                    begin
                        zero_req = 1'b1;
                        kind     = KIND_ZERO_ACK;
                    end
                    default:
                        ;
                endcase
                r.motor_number     = m[7:0];
                r.temperature      = temps[m];
                r.current_raw      = currents[m];
                r.velocity         = speeds[m];
                r.encoder_position = encoders[m];
                r.voltage_a        = volts_a[m];
                r.voltage_b        = volts_b[m];
                r.turn_angle       = angles[m];
                r.fault            = faults[m];
                r.reset_request    = zero_req;
            end
            r.update_kind = kind;
            kind_total[int'(kind)]++;
            expected_replies = {expected_replies, r};
        endfunction

        function void compare(string field, logic [47:0] want, logic [47:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
                failures++;
            end
        endfunction

        // Checks one reply taken from the block against the oldest prediction.
        function void check_reply(result_t got);
            result_t want;
            if (expected_replies.size() == 0)
            begin
                $error("reply with no frame outstanding: kind %0d, motor %0d",
                       got.update_kind, got.motor_number);
                failures++;
                return;
            end
            want = expected_replies.pop_front();
            compare("update_kind", 48'(want.update_kind), 48'(got.update_kind));
            compare("motor_number", 48'(want.motor_number), 48'(got.motor_number));
            compare("temperature", 48'(want.temperature), 48'(got.temperature));
            compare("current_raw", 48'(want.current_raw), 48'(got.current_raw));
            compare("velocity", 48'(want.velocity), 48'(got.velocity));
            compare("encoder_position", 48'(want.encoder_position),
                    48'(got.encoder_position));
            compare("voltage_a", 48'(want.voltage_a), 48'(got.voltage_a));
            compare("voltage_b", 48'(want.voltage_b), 48'(got.voltage_b));
            compare("turn_angle", want.turn_angle, got.turn_angle);
            compare("fault", 48'(want.fault), 48'(got.fault));
            compare("reset_request", 48'(want.reset_request), 48'(got.reset_request));
        endfunction
    endclass

    // Reply codes that the decoder must accept without touching any table.
    localparam logic [7:0] CMD_PASSIVE_B3 = 8'hB3;
    localparam logic [7:0] CMD_PASSIVE_43 = 8'h43;
    localparam logic [7:0] CMD_UNLISTED   = 8'h00;

    // Roughly 1600 random frames, spread over six phases of response base settings.
    localparam int PHASE_FRAMES = 270;
    localparam int PHASE_COUNT  = 6;

    logic clk;
    logic rst_n;

    mcrd_chan_if #(.payload_t(frame_t))   frame_ch ();
    mcrd_chan_if #(.payload_t(result_t))  reply_ch ();
    mcrd_chan_if #(.payload_t(base_id_t)) cfg_ch ();

    motor_can_response_decoder dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .frame  (frame_ch),
        .result (reply_ch),
        .cfg    (cfg_ch)
    );

    motor_state_board board;

    // Stretches in which one side never idles; the counters run down per transaction.
    int unsigned frame_calm;
    int unsigned reply_calm;
    int unsigned bases_used;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Draws the wait before the next transaction on one side. Every so often a run of
    // back-to-back transactions is started so that the block also sees full rate.
    function automatic int unsigned draw_gap(ref int unsigned calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
            calm = $urandom_range(20, 60);
        return $urandom_range(0, 15);
    endfunction

    function automatic frame_t make_frame(logic ext, logic [28:0] id, logic [3:0] len,
                                          logic [7:0] code, logic [55:0] data);
        return {ext, id, len, code, data};
    endfunction

    // Picks a reply code: mostly codes the decoder knows, sometimes any byte at all.
    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 16))
            0:       return CMD_STATUS;
            1:       return CMD_TORQUE;
            2:       return CMD_SPEED;
            3:       return CMD_POS_ABS;
            4:       return CMD_POS_INC_A6;
            5:       return CMD_POS_INC_A8;
            6:       return CMD_POS_INC_A9;
            7:       return CMD_MOTOR_OFF;
            8:       return CMD_MOTOR_STOP;
            9, 10:   return CMD_ERROR_STATUS;
            11, 12:  return CMD_ANGLE;
            13:      return CMD_ZERO_ACK;
            14:      return CMD_PASSIVE_B3;
            15:      return CMD_PASSIVE_43;
            default: return 8'($urandom);
        endcase
    endfunction

    // Builds a random frame that lands in the current window most of the time. A few
    // motors at both ends of the window are favored so that updates of one entry are
    // read back by later frames. Near the top of the identifier range the window is
    // cut short at 0x7FF, so the motor number is bounded by what is still reachable.
    function automatic frame_t random_frame(base_id_t base);
        frame_t f;
        int     top;
        int     m;
        top = int'(base) > 'h700 ? 'h7FF - int'(base) : MOTOR_SLOTS_DEF - 1;
        f = '0;
        f.is_extended = ($urandom_range(0, 15) == 0);
        f.can_id      = 29'($urandom);
        if ($urandom_range(0, 9) < 8)
        begin
            case ($urandom_range(0, 7))
                0:       m = 0;
                1:       m = top > 0 ? 1 : 0;
                2:       m = top;
                3:       m = top > 0 ? top - 1 : 0;
                default: m = $urandom_range(0, top);
            endcase
            f.can_id[10:0] = base + 11'(m);
        end
        f.length_code = ($urandom_range(0, 9) < 7) ? FULL_LENGTH : 4'($urandom_range(0, 15));
        f.byte0 = pick_code();
        {f.byte1, f.byte2, f.byte3, f.byte4} = $urandom;
        {f.byte5, f.byte6, f.byte7}          = 24'($urandom);
        // A clean error word must show up often enough to clear the fault flag again.
        if (f.byte0 == CMD_ERROR_STATUS && $urandom_range(0, 2) == 0)
            {f.byte7, f.byte6} = 16'd0;
        return f;
    endfunction

    // Offers one frame and returns at the clock edge where it is accepted. Valid stays
    // high after acceptance so that a frame sent with no gap keeps it high throughout.
    task automatic send_frame(frame_t f);
        int unsigned gap;
        gap = draw_gap(frame_calm);
        if (gap > 0)
        begin
            frame_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        frame_ch.valid   <= 1'b1;
        frame_ch.payload <= f;
        @(posedge clk);
        while (!frame_ch.ready)
            @(posedge clk);
        board.note_frame(f);
    endtask

    task automatic send_random(int unsigned count);
        repeat (count)
            send_frame(random_frame(board.base));
    endtask

    // Writes the response base. Only called while no frame is in flight.
    task automatic write_base(base_id_t value);
        cfg_ch.valid   <= 1'b1;
        cfg_ch.payload <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        board.set_base(value);
        cfg_ch.valid <= 1'b0;
        bases_used++;
    endtask

    // Stops offering frames and waits for every outstanding reply, then lets the
    // pipeline settle before the next register write.
    task automatic drain_replies();
        frame_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Directed frames, all under the reset base of 0x240.
    task automatic send_directed();
        logic [7:0] status_codes [8];
        status_codes = '{CMD_TORQUE, CMD_SPEED, CMD_POS_ABS, CMD_POS_INC_A6,
                         CMD_POS_INC_A8, CMD_POS_INC_A9, CMD_MOTOR_OFF, CMD_MOTOR_STOP};
        // Status reply with every data bit set, motor 0.
        send_frame(make_frame(1'b0, 29'h240, 4'd8, CMD_STATUS, 56'hFF_FFFF_FFFF_FFFF));
        // Error status with a nonzero error word, upper identifier bits all ones.
        send_frame(make_frame(1'b0, 29'h1FFF_FA40, 4'd8, CMD_ERROR_STATUS,
                              56'h7F_0080_FFFF_0100));
        // Error status with a clean error word clears the fault flag.
        send_frame(make_frame(1'b0, 29'h240, 4'd8, CMD_ERROR_STATUS, 56'h80_3412_7856_0000));
        // Angles on the last motor of the window: most negative side and most positive.
        send_frame(make_frame(1'b0, 29'h33F, 4'd8, CMD_ANGLE, 56'h00_0102_0304_0580));
        send_frame(make_frame(1'b0, 29'h33F, 4'd8, CMD_ANGLE, 56'hAA_FFFF_FFFF_FF7F));
        // Zero-set acknowledgement at the shortest and the longest length.
        send_frame(make_frame(1'b0, 29'h243, 4'd1, CMD_ZERO_ACK, 56'h0));
        send_frame(make_frame(1'b0, 29'h243, 4'd15, CMD_ZERO_ACK, 56'h12_3456_789A_BCDE));
        // Codes that are accepted but leave the tables alone.
        send_frame(make_frame(1'b0, 29'h240, 4'd8, CMD_PASSIVE_B3, 56'h11_1111_1111_1111));
        send_frame(make_frame(1'b0, 29'h240, 4'd8, CMD_PASSIVE_43, 56'h22_2222_2222_2222));
        send_frame(make_frame(1'b0, 29'h240, 4'd8, CMD_UNLISTED, 56'h33_3333_3333_3333));
        // Update codes that are short of a full frame must not store anything.
        send_frame(make_frame(1'b0, 29'h241, 4'd7, CMD_STATUS, 56'h44_4444_4444_4444));
        send_frame(make_frame(1'b0, 29'h241, 4'd1, CMD_ERROR_STATUS, 56'h55_5555_5555_5555));
        send_frame(make_frame(1'b0, 29'h33F, 4'd7, CMD_ANGLE, 56'h66_6666_6666_6666));
        // A length above 8 counts as a full frame.
        send_frame(make_frame(1'b0, 29'h241, 4'd15, CMD_STATUS, 56'h19_38FF_C800_3412));
        // Dropped frames: zero length, extended, just below and just past the window.
        send_frame(make_frame(1'b0, 29'h241, 4'd0, CMD_STATUS, 56'h77_7777_7777_7777));
        send_frame(make_frame(1'b1, 29'h241, 4'd8, CMD_STATUS, 56'h88_8888_8888_8888));
        send_frame(make_frame(1'b0, 29'h23F, 4'd8, CMD_STATUS, 56'h99_9999_9999_9999));
        send_frame(make_frame(1'b0, 29'h340, 4'd8, CMD_STATUS, 56'hAA_AAAA_AAAA_AAAA));
        // Every other status code, one motor each.
        foreach (status_codes[i])
            send_frame(make_frame(1'b0, 29'h242 + 29'(i), 4'd8, status_codes[i],
                                  {8'(i * 9 + 3), 16'(i * 4099), 16'(-i * 77),
                                   16'(i * 8191)}));
    endtask

    // Reply side: takes replies with random stalls and checks each one.
    initial
    begin
        int unsigned gap;
        reply_ch.ready = 1'b0;
        reply_calm = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = draw_gap(reply_calm);
            if (gap > 0)
            begin
                reply_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            reply_ch.ready <= 1'b1;
            @(posedge clk);
            while (!reply_ch.valid)
                @(posedge clk);
            board.check_reply(reply_ch.payload);
        end
    end

    // Main sequence: reset, directed frames under the reset base, then random phases
    // under the reset base, the lowest base, the highest base, a base whose window
    // runs past 0x7FF, a random base and the reset value written back explicitly.
    initial
    begin
        base_id_t phase_bases [PHASE_COUNT];
        board = new();
        frame_calm = 0;
        bases_used = 1;
        rst_n            = 1'b0;
        frame_ch.valid   = 1'b0;
        frame_ch.payload = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.payload   = '0;
        phase_bases = '{RESP_BASE_RESET, 11'h000, 11'h7FF, 11'h701,
                        base_id_t'($urandom_range(0, 2047)), RESP_BASE_RESET};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_directed();
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            // The first phase runs on the base the block comes out of reset with.
            if (p > 0)
                write_base(phase_bases[p]);
            send_random(PHASE_FRAMES);
            drain_replies();
        end
        repeat (10) @(posedge clk);

        $display("Ran %0d phases over %0d response base settings; replies seen by kind:",
                 PHASE_COUNT, bases_used);
        $display("  %0d status, %0d error status, %0d angle, %0d zero-set, %0d other, %0d dropped",
                 board.kind_total[KIND_STATUS], board.kind_total[KIND_ERROR],
                 board.kind_total[KIND_ANGLE], board.kind_total[KIND_ZERO_ACK],
                 board.kind_total[KIND_OTHER], board.kind_total[KIND_IGNORED]);
        if (board.failures == 0 && board.pending() == 0)
            $display("motor_can_response_decoder test passed");
        else
            $display("motor_can_response_decoder test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("motor_can_response_decoder test failed");
        $finish;
    end

endmodule

// File: motor_can_response_decoder.f
src/mcrd_pkg.sv
src/mcrd_chan_if.sv
src/mcrd_ram.sv
src/mcrd_ctrl.sv
src/mcrd_datapath.sv
src/motor_can_response_decoder.sv
tb/tb_motor_can_response_decoder.sv
